// ===== sv/lsfp_pkg.sv =====
// Shared types and constants for the scan frame parser.
// Used by lsfp_step and lidar_scan_frame_parser_unit; no dependencies.
package lsfp_pkg;

  localparam int LINE_CHARS = 64;
  localparam int LC_W       = $clog2(LINE_CHARS + 1);

  localparam int CNT_W  = 10;              // register and point index width
  localparam int CHAR_W = 12;              // data character counter width
  localparam int DIST_W = 18;

  // register indexes
  localparam logic [1:0] REG_POINT_COUNT  = 2'd0;
  localparam logic [1:0] REG_WINDOW_FIRST = 2'd1;
  localparam logic [1:0] REG_WINDOW_LAST  = 2'd2;

  localparam logic [CNT_W-1:0] POINT_COUNT_RST  = 10'd682;
  localparam logic [CNT_W-1:0] WINDOW_FIRST_RST = 10'd0;
  localparam logic [CNT_W-1:0] WINDOW_LAST_RST  = 10'd682;

  // result kinds
  localparam logic [1:0] KIND_POINT     = 2'd0;
  localparam logic [1:0] KIND_MISALIGN  = 2'd1;
  localparam logic [1:0] KIND_FRAME_OK  = 2'd2;
  localparam logic [1:0] KIND_FRAME_BAD = 2'd3;

  // byte codes
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_M     = 8'h4D;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CHAR_BIAS = 8'h30;

  // parser phases
  localparam logic [3:0] PH_HDR0   = 4'd0;
  localparam logic [3:0] PH_HDR1   = 4'd1;
  localparam logic [3:0] PH_ECHO   = 4'd2;
  localparam logic [3:0] PH_ST0    = 4'd3;
  localparam logic [3:0] PH_ST1    = 4'd4;
  localparam logic [3:0] PH_ST2    = 4'd5;
  localparam logic [3:0] PH_STLINE = 4'd6;
  localparam logic [3:0] PH_TSLINE = 4'd7;
  localparam logic [3:0] PH_DATA   = 4'd8;
  localparam logic [3:0] PH_SUM    = 4'd9;
  localparam logic [3:0] PH_NL     = 4'd10;
  localparam logic [3:0] PH_ESUM   = 4'd11;
  localparam logic [3:0] PH_ENL1   = 4'd12;
  localparam logic [3:0] PH_ENL2   = 4'd13;
  localparam logic [3:0] PH_BLANK  = 4'd14;

  typedef struct packed {
    logic [3:0]        phase;
    logic              header_match;
    logic [CHAR_W-1:0] char_count;
    logic [LC_W-1:0]   line_count;
    logic [1:0]        digit_pos;
    logic [11:0]       partial_value;
    logic              seen_newline;
    logic [CNT_W-1:0]  point_ctr;      // char_count / 3, kept alongside
  } parse_state_t;

  typedef struct packed {
    logic              valid;
    logic [1:0]        kind;
    logic [DIST_W-1:0] distance_mm;
    logic [CNT_W-1:0]  point_index;
    logic              last_point;
  } parse_result_t;

  typedef struct packed {
    logic [CNT_W-1:0] point_count;
    logic [CNT_W-1:0] window_first;
    logic [CNT_W-1:0] window_last;
  } parse_cfg_t;

endpackage

// ===== sv/lsfp_step.sv =====
// Per-byte next-state and result logic of the scan frame parser.
// Depends on lsfp_pkg.
module lsfp_step import lsfp_pkg::*; (
  input  parse_state_t  cur,
  input  logic [7:0]    rx_byte,
  input  parse_cfg_t    cfg,
  output parse_state_t  nxt,
  output parse_result_t res
);

  logic [CHAR_W-1:0] total;
  logic [CHAR_W-1:0] cc_inc;
  logic [LC_W-1:0]   lc_inc;
  logic [7:0]        diff;
  logic [5:0]        digit;
  logic              in_win;
  logic              is_last;
  logic              is_nl;

  assign total   = {2'b00, cfg.point_count} + {1'b0, cfg.point_count, 1'b0};
  assign cc_inc  = cur.char_count + 1'b1;
  assign lc_inc  = cur.line_count + 1'b1;
  assign diff    = rx_byte - CHAR_BIAS;
  assign digit   = diff[5:0];
  assign in_win  = (cur.point_ctr >= cfg.window_first) && (cur.point_ctr <= cfg.window_last);
  assign is_last = ({1'b0, cur.point_ctr} + 1'b1) == {1'b0, cfg.point_count};
  assign is_nl   = (rx_byte == CH_NL);

  always_comb begin
    nxt = cur;
    res = '0;
    unique case (cur.phase)
      PH_HDR0: begin
        nxt.header_match = (rx_byte == CH_M);
        nxt.phase        = PH_HDR1;
      end
      PH_HDR1: begin
        if (cur.header_match && rx_byte == CH_D) begin
          nxt.phase = PH_ECHO;
        end else begin
          nxt.seen_newline = 1'b0;
          nxt.phase        = PH_BLANK;
        end
      end
      PH_ECHO: begin
        if (is_nl) nxt.phase = PH_ST0;
      end
      PH_ST0: begin
        nxt.header_match = (rx_byte == CH_9);
        nxt.phase        = PH_ST1;
      end
      PH_ST1: begin
        if (rx_byte != CH_9) nxt.header_match = 1'b0;
        nxt.phase = PH_ST2;
      end
      PH_ST2: begin
        if (cur.header_match && rx_byte == CH_B) begin
          nxt.phase = PH_STLINE;
        end else begin
          nxt.seen_newline = 1'b0;
          nxt.phase        = PH_BLANK;
        end
      end
      PH_STLINE: begin
        if (is_nl) nxt.phase = PH_TSLINE;
      end
      PH_TSLINE: begin
        if (is_nl) begin
          nxt.char_count    = '0;
          nxt.line_count    = '0;
          nxt.digit_pos     = '0;
          nxt.partial_value = '0;
          nxt.point_ctr     = '0;
          nxt.header_match  = 1'b1;
          nxt.phase         = (total == '0) ? PH_ESUM : PH_DATA;
        end
      end
      PH_DATA: begin
        if (cur.digit_pos < 2'd2) begin
          nxt.partial_value = {cur.partial_value[5:0], digit};
          nxt.digit_pos     = cur.digit_pos + 2'd1;
        end else begin
          if (in_win) begin
            res.valid       = 1'b1;
            res.kind        = KIND_POINT;
            res.distance_mm = {cur.partial_value, digit};
            res.point_index = cur.point_ctr - cfg.window_first;
            res.last_point  = is_last;
          end
          nxt.digit_pos     = '0;
          nxt.partial_value = '0;
          nxt.point_ctr     = cur.point_ctr + 1'b1;
        end
        nxt.char_count = cc_inc;
        nxt.line_count = lc_inc;
        if (cc_inc >= total)
          nxt.phase = PH_ESUM;
        else if (lc_inc >= LC_W'(LINE_CHARS))
          nxt.phase = PH_SUM;
      end
      PH_SUM: nxt.phase = PH_NL;
      PH_NL: begin
        if (!is_nl) begin
          res.valid = 1'b1;
          res.kind  = KIND_MISALIGN;
        end
        nxt.line_count = '0;
        nxt.phase      = PH_DATA;
      end
      PH_ESUM: begin
        nxt.header_match = 1'b1;
        nxt.phase        = PH_ENL1;
      end
      PH_ENL1: begin
        if (!is_nl) nxt.header_match = 1'b0;
        nxt.phase = PH_ENL2;
      end
      PH_ENL2: begin
        res.valid        = 1'b1;
        res.kind         = (cur.header_match && is_nl) ? KIND_FRAME_OK : KIND_FRAME_BAD;
        nxt.header_match = 1'b0;
        nxt.phase        = PH_HDR0;
      end
      PH_BLANK: begin
        if (cur.seen_newline) begin
          nxt.seen_newline = 1'b0;
          if (is_nl) nxt.phase = PH_HDR0;
        end else if (is_nl) begin
          nxt.seen_newline = 1'b1;
        end
      end
      default: nxt.phase = PH_HDR0;
    endcase
  end

endmodule

// ===== sv/lidar_scan_frame_parser_unit.sv =====
// Top level of the scan frame parser: config registers, input and result registers.
// Depends on lsfp_pkg and lsfp_step.
//
// Usage:
//   rx channel  : rx_valid / rx_stall / rx_byte, one serial byte per beat.
//   res channel : res_valid / res_stall / kind, distance_mm, point_index,
//                 last_point; at most one result beat per received byte.
//   cfg port    : cfg_we / cfg_index / cfg_data, write-only; index 0 point
//                 count, 1 first window index, 2 last window index. Others
//                 are ignored.
// Timing: a byte taken into the input register is decoded between the input register
//   and the result register; its result (if any) is registered there and shows at
//   res_*. One byte per cycle sustained while res_stall does not hold a result beat:
//   the parse state update is combinational logic in lsfp_step.
// Stall: while a result beat waits under res_stall the input register holds
//   its byte and rx_stall rises only once that register is full, so one
//   extra byte is absorbed before the sender sees back-pressure.
// Reset: rst (sync, active high) empties both registers, puts the parser
//   back to hunting the first header byte and loads the register defaults
//   (682 points, window 0..682).
module lidar_scan_frame_parser_unit import lsfp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             rx_valid,
  output logic             rx_stall,
  input  logic [7:0]       rx_byte,
  output logic             res_valid,
  input  logic             res_stall,
  output logic [1:0]       kind,
  output logic [DIST_W-1:0] distance_mm,
  output logic [CNT_W-1:0] point_index,
  output logic             last_point,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CNT_W-1:0] cfg_data
);

  parse_cfg_t    cfg;
  parse_state_t  st;
  parse_state_t  st_next;
  parse_result_t step_res;

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       adv;            // input register moves into the result stage

  assign adv      = !res_valid || !res_stall;
  assign rx_stall = s1_valid && !adv;

  // config registers, live during the frame
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.point_count  <= POINT_COUNT_RST;
      cfg.window_first <= WINDOW_FIRST_RST;
      cfg.window_last  <= WINDOW_LAST_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_POINT_COUNT:  cfg.point_count  <= cfg_data;
        REG_WINDOW_FIRST: cfg.window_first <= cfg_data;
        REG_WINDOW_LAST:  cfg.window_last  <= cfg_data;
        default: ;
      endcase
    end
  end

  lsfp_step u_step (
    .cur     (st),
    .rx_byte (s1_byte),
    .cfg     (cfg),
    .nxt     (st_next),
    .res     (step_res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!rx_stall) begin
      s1_valid <= rx_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rx_stall) s1_byte <= rx_byte;
  end

  // parse state advances once per decoded byte
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '{phase: PH_HDR0, default: '0};
    end else if (s1_valid && adv) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= s1_valid && step_res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      kind        <= step_res.kind;
      distance_mm <= step_res.distance_mm;
      point_index <= step_res.point_index;
      last_point  <= step_res.last_point;
    end
  end

  // checks
  a_nonpoint_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && kind != KIND_POINT |-> distance_mm == '0 && point_index == '0 && !last_point)
    else $error("non-point result carries point fields");

  a_digit_pos: assert property (@(posedge clk) disable iff (rst)
    st.digit_pos != 2'd3)
    else $error("digit position out of range");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid && !s1_valid)
    else $error("pipeline not empty after reset");

  a_point_in_data: assert property (@(posedge clk) disable iff (rst)
    s1_valid && adv && step_res.valid && step_res.kind == KIND_POINT |-> st.phase == PH_DATA)
    else $error("point result outside payload");

endmodule

// ===== test/tb_lidar_scan_frame_parser_unit.sv =====
`timescale 1ns / 1ps
// Testbench for lidar_scan_frame_parser_unit: a short directed script, then random scan
// streams, with every result beat checked against an in-bench copy of the parser.
// Depends on lsfp_pkg and the parser RTL only.
module tb_lidar_scan_frame_parser_unit;
  import lsfp_pkg::*;

  logic              clk;
  logic              rst;
  logic              rx_valid;
  logic              rx_stall;
  logic [7:0]        rx_byte;
  logic              res_valid;
  logic              res_stall;
  logic [1:0]        kind;
  logic [DIST_W-1:0] distance_mm;
  logic [CNT_W-1:0]  point_index;
  logic              last_point;
  logic              cfg_we;
  logic [1:0]        cfg_index;
  logic [CNT_W-1:0]  cfg_data;

  lidar_scan_frame_parser_unit u_dut (
    .clk         (clk),
    .rst         (rst),
    .rx_valid    (rx_valid),
    .rx_stall    (rx_stall),
    .rx_byte     (rx_byte),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .kind        (kind),
    .distance_mm (distance_mm),
    .point_index (point_index),
    .last_point  (last_point),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  // Register shadow, updated as each write goes out.
  logic [CNT_W-1:0]  pts_per_scan;
  logic [CNT_W-1:0]  win_lo;
  logic [CNT_W-1:0]  win_hi;

  // Parser shadow state.
  logic [3:0]        ph;
  logic              hdr_ok;
  logic [CHAR_W-1:0] n_chars;
  logic [LC_W-1:0]   n_line;
  logic [1:0]        dig;
  logic [11:0]       part;
  logic              nl_seen;

  parse_result_t     due_results[$];   // result beats still owed by the block, oldest first
  logic [7:0]        tx_plan[$];       // bytes of the frame being built
  int                errors;
  int                good_bytes;       // bytes of well-formed frames sent after the directed script
  bit                calm;             // no idling on either side while set

  // One row of the directed script: a register write or a byte. A pinned row carries
  // its expected outcome typed in (possibly "no result"); other bytes go by the shadow.
  typedef struct {
    bit               wr;
    logic [1:0]       idx;
    logic [CNT_W-1:0] val;
    logic [7:0]       b;
    bit               typed;
    parse_result_t    want;
  } script_row_t;

  script_row_t script[$];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin : watchdog
    #5_000_000;
    $display("tb_lidar_scan_frame_parser_unit: errors");
    $finish;
  end

  task automatic flag(input string what);
    errors++;
    if (errors <= 40) $display("%0t mismatch: %s", $time, what);
  endtask

  // Parser shadow: advances one byte and returns the result beat it causes, if any.
  function automatic parse_result_t parse_byte(input logic [7:0] b);
    parse_result_t r;
    int unsigned   span;
    int unsigned   p;
    logic [5:0]    d;
    r = '0;
    span = pts_per_scan * 3;   // a 10-bit count never goes past the 1023 cap
    case (ph)
      PH_HDR0: begin
        hdr_ok = (b == CH_M);
        ph = PH_HDR1;
      end
      PH_HDR1: begin
        if (hdr_ok && b == CH_D) begin
          ph = PH_ECHO;
        end else begin
          nl_seen = 1'b0;
          ph = PH_BLANK;
        end
      end
      PH_ECHO: begin
        if (b == CH_NL) ph = PH_ST0;
      end
      PH_ST0: begin
        hdr_ok = (b == CH_9);
        ph = PH_ST1;
      end
      PH_ST1: begin
        if (b != CH_9) hdr_ok = 1'b0;
        ph = PH_ST2;
      end
      PH_ST2: begin
        if (hdr_ok && b == CH_B) begin
          ph = PH_STLINE;
        end else begin
          nl_seen = 1'b0;
          ph = PH_BLANK;
        end
      end
      PH_STLINE: begin
        if (b == CH_NL) ph = PH_TSLINE;
      end
      PH_TSLINE: begin
        if (b == CH_NL) begin
          n_chars = '0;
          n_line  = '0;
          dig     = '0;
          part    = '0;
          hdr_ok  = 1'b1;
          ph = (span == 0) ? PH_ESUM : PH_DATA;
        end
      end
      PH_DATA: begin
        d = 6'(b - CHAR_BIAS);
        if (dig < 2) begin
          part = {part[5:0], d};
          dig  = dig + 2'd1;
        end else begin
          p = n_chars / 3;
          if (p >= win_lo && p <= win_hi) begin
            r.valid       = 1'b1;
            r.kind        = KIND_POINT;
            r.distance_mm = {part, d};
            r.point_index = CNT_W'(p - win_lo);
            r.last_point  = (p + 1 == pts_per_scan);
          end
          dig  = '0;
          part = '0;
        end
        n_chars = n_chars + 1'b1;
        n_line  = n_line + 1'b1;
        // live count: a smaller count written mid-payload ends it here
        if (n_chars >= span) ph = PH_ESUM;
        else if (n_line >= LINE_CHARS) ph = PH_SUM;
      end
      PH_SUM: begin
        ph = PH_NL;
      end
      PH_NL: begin
        if (b != CH_NL) begin
          r.valid = 1'b1;
          r.kind  = KIND_MISALIGN;
        end
        n_line = '0;
        ph = PH_DATA;
      end
      PH_ESUM: begin
        hdr_ok = 1'b1;
        ph = PH_ENL1;
      end
      PH_ENL1: begin
        if (b != CH_NL) hdr_ok = 1'b0;
        ph = PH_ENL2;
      end
      PH_ENL2: begin
        if (b != CH_NL) hdr_ok = 1'b0;
        r.valid = 1'b1;
        r.kind  = hdr_ok ? KIND_FRAME_OK : KIND_FRAME_BAD;
        hdr_ok = 1'b0;
        ph = PH_HDR0;
      end
      PH_BLANK: begin
        // resync needs two newlines back to back
        if (nl_seen) begin
          nl_seen = 1'b0;
          if (b == CH_NL) ph = PH_HDR0;
        end else if (b == CH_NL) begin
          nl_seen = 1'b1;
        end
      end
      default: begin
        ph = PH_HDR0;
      end
    endcase
    return r;
  endfunction

  // Script row builders.
  function automatic script_row_t byte_row(input logic [7:0] b);
    script_row_t s;
    s = '{wr: 1'b0, idx: '0, val: '0, b: b, typed: 1'b0, want: '0};
    return s;
  endfunction

  function automatic script_row_t pinned_row(input logic [7:0] b, input bit v,
                                             input logic [1:0] k,
                                             input logic [DIST_W-1:0] d,
                                             input logic [CNT_W-1:0] i, input bit l);
    script_row_t s;
    s = byte_row(b);
    s.typed = 1'b1;
    s.want  = '{valid: v, kind: k, distance_mm: d, point_index: i, last_point: l};
    return s;
  endfunction

  function automatic script_row_t reg_row(input logic [1:0] idx, input logic [CNT_W-1:0] val);
    script_row_t s;
    s = '{wr: 1'b1, idx: idx, val: val, b: '0, typed: 1'b0, want: '0};
    return s;
  endfunction

  // Shortest legal header: "MD", newline, "99b", newline, empty timestamp line.
  function automatic void script_header();
    script.push_back(byte_row(CH_M));
    script.push_back(byte_row(CH_D));
    script.push_back(byte_row(CH_NL));
    script.push_back(byte_row(CH_9));
    script.push_back(byte_row(CH_9));
    script.push_back(byte_row(CH_B));
    script.push_back(byte_row(CH_NL));
    script.push_back(byte_row(CH_NL));
  endfunction

  // Random byte that differs from one value.
  function automatic logic [7:0] any_but(input logic [7:0] avoid);
    logic [7:0] v;
    v = 8'($urandom_range(0, 254));
    if (v >= avoid) v++;
    return v;
  endfunction

  function automatic logic [7:0] line_end();
    return ($urandom_range(0, 99) < 90) ? CH_NL : any_but(CH_NL);
  endfunction

  function automatic void add_junk(input int n);
    repeat (n) tx_plan.push_back(any_but(CH_NL));
  endfunction

  // Well-formed frame for the current point count, random content; a tenth of the
  // line ends are damaged so misaligned lines and bad frame ends show up.
  function automatic void add_scan();
    int unsigned span;
    span = pts_per_scan * 3;
    tx_plan.push_back(CH_M);
    tx_plan.push_back(CH_D);
    add_junk($urandom_range(0, 3));
    tx_plan.push_back(CH_NL);
    tx_plan.push_back(CH_9);
    tx_plan.push_back(CH_9);
    tx_plan.push_back(CH_B);
    add_junk($urandom_range(0, 3));
    tx_plan.push_back(CH_NL);
    add_junk($urandom_range(0, 4));    // timestamp line
    tx_plan.push_back(CH_NL);
    for (int k = 1; k <= span; k++) begin
      tx_plan.push_back(($urandom_range(0, 99) < 85) ? 8'($urandom_range(8'h30, 8'h6F))
                                                     : 8'($urandom));
      if (k < span && k % LINE_CHARS == 0) begin
        tx_plan.push_back(8'($urandom));   // checksum, skipped by the block
        tx_plan.push_back(line_end());
      end
    end
    tx_plan.push_back(8'($urandom));
    tx_plan.push_back(line_end());
    tx_plan.push_back(line_end());
  endfunction

  // Header with one wrong byte in "MD" or "99b", then a blank line to resync.
  function automatic void add_broken();
    logic [7:0] grp [5];
    int         bad;
    int         top;
    grp = '{CH_M, CH_D, CH_9, CH_9, CH_B};
    bad = $urandom_range(0, 4);
    top = (bad < 2) ? 1 : 4;
    for (int i = 0; i <= top; i++) begin
      if (i == 2) begin
        add_junk($urandom_range(0, 3));
        tx_plan.push_back(CH_NL);
      end
      tx_plan.push_back((i == bad) ? any_but(grp[i]) : grp[i]);
    end
    add_junk($urandom_range(0, 5));
    tx_plan.push_back(CH_NL);
    tx_plan.push_back(CH_NL);
  endfunction

  // Line noise between frames: never starts a header, ends in a blank line.
  function automatic void add_noise();
    tx_plan.push_back(any_but(CH_M));
    add_junk($urandom_range(1, 7));
    tx_plan.push_back(CH_NL);
    tx_plan.push_back(CH_NL);
  endfunction

  // Sends one byte beat. Called and returns right after a falling edge. The shadow
  // predicts first, so the expected beat is queued long before it can show up.
  task automatic put_byte(input logic [7:0] b, input bit typed, input parse_result_t pinned);
    parse_result_t got;
    got = parse_byte(b);
    if (typed) got = pinned;
    if (got.valid) due_results.push_back(got);
    while (!calm && $urandom_range(0, 99) < 22) begin
      rx_valid <= 1'b0;
      @(negedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (rx_stall);
    @(negedge clk);
  endtask

  task automatic flush_plan(input bit counts);
    while (tx_plan.size() != 0) begin
      put_byte(tx_plan.pop_front(), 1'b0, '0);
      if (counts) good_bytes++;
    end
  endtask

  // Wait for every owed beat, then let the two-stage pipe empty out, since bytes
  // that cause no result may still be in flight.
  task automatic settle();
    rx_valid <= 1'b0;
    while (due_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CNT_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    case (idx)
      REG_POINT_COUNT:  pts_per_scan = val;
      REG_WINDOW_FIRST: win_lo = val;
      REG_WINDOW_LAST:  win_hi = val;
      default: ;
    endcase
  endtask

  task automatic load_regs(input int pc, input int lo, input int hi);
    settle();
    write_reg(REG_POINT_COUNT, CNT_W'(pc));
    write_reg(REG_WINDOW_FIRST, CNT_W'(lo));
    write_reg(REG_WINDOW_LAST, CNT_W'(hi));
  endtask

  // Result side: stall at random, sampled with the beat at the rising edge.
  initial begin : result_stall
    res_stall = 1'b0;
    forever begin
      @(negedge clk);
      res_stall <= !calm && ($urandom_range(0, 99) < 22);
    end
  end

  // Every accepted result beat must match the oldest owed one.
  always @(posedge clk) begin : check_beat
    parse_result_t head;
    if (!rst && res_valid && !res_stall) begin
      if (due_results.size() == 0) begin
        flag($sformatf("result beat with nothing owed, kind %0d", kind));
      end else begin
        head = due_results.pop_front();
        if (kind !== head.kind || distance_mm !== head.distance_mm ||
            point_index !== head.point_index || last_point !== head.last_point)
          flag($sformatf("kind %0d dist %0d idx %0d last %0d, want %0d %0d %0d %0d",
                         kind, distance_mm, point_index, last_point,
                         head.kind, head.distance_mm, head.point_index, head.last_point));
      end
    end
  end

  initial begin : stimulus
    int pc;
    int lo;
    int hi;
    int pick;
    int frames;
    bit cut;

    rst        = 1'b1;
    rx_valid   = 1'b0;
    rx_byte    = '0;
    cfg_we     = 1'b0;
    cfg_index  = REG_POINT_COUNT;
    cfg_data   = '0;
    errors     = 0;
    good_bytes = 0;
    calm       = 1'b0;

    pts_per_scan = POINT_COUNT_RST;
    win_lo       = WINDOW_FIRST_RST;
    win_hi       = WINDOW_LAST_RST;
    ph      = PH_HDR0;
    hdr_ok  = 1'b0;
    n_chars = '0;
    n_line  = '0;
    dig     = '0;
    part    = '0;
    nl_seen = 1'b0;

    // Directed script.
    // Out of reset: a first group that is not "MD" sends the parser to the blank-line
    // hunt; nothing comes out.
    script.push_back(pinned_row(CH_M, 1'b0, KIND_POINT, '0, '0, 1'b0));
    script.push_back(pinned_row(8'hFF, 1'b0, KIND_POINT, '0, '0, 1'b0));
    script.push_back(pinned_row(CH_NL, 1'b0, KIND_POINT, '0, '0, 1'b0));
    script.push_back(pinned_row(CH_NL, 1'b0, KIND_POINT, '0, '0, 1'b0));
    // One point, window 0..0: all-max characters give the largest distance, and it is
    // the last point; a bad second closing byte marks the frame end bad.
    script.push_back(reg_row(REG_POINT_COUNT, 10'd1));
    script.push_back(reg_row(REG_WINDOW_FIRST, 10'd0));
    script.push_back(reg_row(REG_WINDOW_LAST, 10'd0));
    script_header();
    script.push_back(byte_row(8'h6F));
    script.push_back(byte_row(8'h6F));
    script.push_back(pinned_row(8'h6F, 1'b1, KIND_POINT, 18'h3FFFF, '0, 1'b1));
    script.push_back(byte_row(8'h00));
    script.push_back(byte_row(CH_NL));
    script.push_back(pinned_row(8'hFF, 1'b1, KIND_FRAME_BAD, '0, '0, 1'b0));
    // Zero points: the payload is only checksum, newline, newline.
    script.push_back(reg_row(REG_POINT_COUNT, 10'd0));
    script_header();
    script.push_back(byte_row(8'h30));
    script.push_back(byte_row(CH_NL));
    script.push_back(pinned_row(CH_NL, 1'b1, KIND_FRAME_OK, '0, '0, 1'b0));

    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (script[i]) begin
      if (script[i].wr) begin
        settle();
        write_reg(script[i].idx, script[i].val);
      end else begin
        put_byte(script[i].b, script[i].typed, script[i].want);
      end
    end

    // Random part: mostly well-formed frames with random content, some broken
    // headers and noise. Each phase runs its own register setting.
    while (good_bytes < 900) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) pc = $urandom_range(1, 8);
      else if (pick < 85) pc = $urandom_range(22, 60);   // crosses payload line ends
      else if (pick < 92) pc = 0;
      else pc = $urandom_range(9, 21);
      pick = $urandom_range(0, 99);
      if (pick < 50) lo = 0;
      else if (pick < 90) lo = $urandom_range(0, pc + 2);
      else lo = 1023;
      pick = $urandom_range(0, 99);
      if (pick < 35) hi = 1023;
      else if (pick < 65) hi = lo + $urandom_range(0, 10);
      else if (pick < 90) hi = $urandom_range(0, 1023);   // may leave the window empty
      else hi = 0;
      if (hi > 1023) hi = 1023;
      load_regs(pc, lo, hi);

      calm = (good_bytes >= 300 && good_bytes < 600);
      frames = $urandom_range(1, 4);
      cut = 1'b0;
      for (int f = 0; f < frames && !cut; f++) begin
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
          add_scan();
          // now and then stop mid-frame: the next setting lands while the parser
          // is still inside this payload
          if ($urandom_range(0, 99) < 6) begin
            cut = 1'b1;
            repeat ($urandom_range(1, tx_plan.size() - 1)) void'(tx_plan.pop_back());
          end
          flush_plan(1'b1);
        end else if (pick < 90) begin
          add_broken();
          flush_plan(1'b0);
        end else begin
          add_noise();
          flush_plan(1'b0);
        end
      end
    end
    calm = 1'b0;

    // One long payload with many line ends, window near its end.
    load_regs(150, 140, 1023);
    add_scan();
    flush_plan(1'b1);

    settle();
    if (errors == 0) begin
      $display("tb_lidar_scan_frame_parser_unit: clean");
    end else begin
      $display("tb_lidar_scan_frame_parser_unit: errors");
    end
    $finish;
  end

endmodule
